FILE: src/thermistor_steinhart_hart_temp_macros.svh
// Assertion macros for the thermistor Steinhart-Hart converter.
// Used by thermistor_steinhart_hart_temp.sv; no other dependencies.
`ifndef THERMISTOR_STEINHART_HART_TEMP_MACROS_SVH
`define THERMISTOR_STEINHART_HART_TEMP_MACROS_SVH

// same-cycle implication
`define TSH_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tsh: same-cycle check failed");

// next-cycle implication
`define TSH_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tsh: next-cycle check failed");

`endif

FILE: src/tsh_pkg.sv
// Shared types and constants for the thermistor Steinhart-Hart converter.
// No dependencies.
`timescale 1ns / 1ps

package tsh_pkg;

   localparam int NODE_W   = 23;
   localparam int SUPPLY_W = 23;
   localparam int RF_W     = 20;
   localparam int COEF_W   = 48;
   localparam int GAIN_W   = 18;
   localparam int OFFS_W   = 16;
   localparam int TEMP_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int COEF_FRAC_BITS_DEF = 40;

   localparam logic [SUPPLY_W-1:0]      SUPPLY_RST = 23'd4910000;
   localparam logic [RF_W-1:0]          RFIX_RST   = 20'd9880;
   localparam logic signed [COEF_W-1:0] COEF_A_RST = -48'sd4011568900;
   localparam logic signed [COEF_W-1:0] COEF_B_RST = 48'sd1059479400;
   localparam logic signed [COEF_W-1:0] COEF_C_RST = -48'sd2659588;
   localparam logic [GAIN_W-1:0]        GAIN_RST   = 18'd65536;
   localparam logic signed [OFFS_W-1:0] OFFS_RST   = 16'sd0;

   // clamp margin at both rails, uV
   localparam logic [NODE_W-1:0] RAIL_MARGIN_UV = 23'd1000;

   // ln(2) in Q60
   localparam logic [59:0] LN2_Q60 = 60'hB17217F7D1CF79B;

   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd27315;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
   localparam int KELVIN_CENTI = 27315;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_CLAMPED = 2'd1,
      ST_SAT     = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY  = 3'd0,
      CSR_RFIX    = 3'd1,
      CSR_COEF_A  = 3'd2,
      CSR_COEF_B  = 3'd3,
      CSR_COEF_C  = 3'd4,
      CSR_GAIN    = 3'd5,
      CSR_OFFSET  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic clamped;
      logic inval;
   } meta_type;

endpackage

FILE: src/thermistor_steinhart_hart_temp.sv
// NTC divider node voltage to temperature, Steinhart-Hart, fully pipelined.
// Depends on tsh_pkg and thermistor_steinhart_hart_temp_macros.svh.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | req_node_uv
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_temp_centi_c, rsp_status
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One request enters per cycle unless the output is held; each passes the
// DEPTH stages to the output register, mostly the two 32-step log2 squaring
// chains and the 42-step restoring divider for 1/(1/T), one step per stage.
// Synchronous reset clears the valid chain and loads the default coefficients.
// A stalled result freezes the whole pipe in place; nothing is dropped.
`timescale 1ns / 1ps
`include "thermistor_steinhart_hart_temp_macros.svh"

module thermistor_steinhart_hart_temp #(
   parameter int COEF_FRAC_BITS = tsh_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tsh_pkg::NODE_W-1:0]          req_node_uv,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tsh_pkg::TEMP_W-1:0]   rsp_temp_centi_c,
   output logic [tsh_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsh_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tsh_pkg::*;

   // ---------------------------------------------------------------
   // Sizes
   // ---------------------------------------------------------------
   localparam int X1_W      = RF_W + SUPPLY_W;   // Rf * (Vsup - v)
   localparam int LOG_STEPS = 32;                // fraction bits of log2
   localparam int LG_W      = 38;                // |log2 diff|, Q32
   localparam int LN_W      = 38;
   localparam int LN2_W     = 44;
   localparam int LN3_W     = 50;
   localparam int PB_W      = 55;
   localparam int PC_W      = 66;
   localparam int INV_W     = 68;
   localparam int DIV_STEPS = 42;                // quotient bits
   localparam int NH_W      = 64 - DIV_STEPS;
   localparam int DEPTH     = 4 + (LOG_STEPS + 1) + 11 + (DIV_STEPS + 1) + 3;

   localparam logic [63:0] NUM_BASE = 64'd100 << COEF_FRAC_BITS;
   localparam logic [DIV_STEPS-1:0] CK_CAP =
      (DIV_STEPS'(1) << 40) + DIV_STEPS'(KELVIN_CENTI);
   localparam logic [29:0] LN2_HI = LN2_Q60[59:30];
   localparam logic [29:0] LN2_LO = LN2_Q60[29:0];

   // ---------------------------------------------------------------
   // Configuration registers; not enforced by the block, the user ensures writes only arrive while idle
   // ---------------------------------------------------------------
   logic [SUPPLY_W-1:0]      supply_ff;
   logic [RF_W-1:0]          rfix_ff;
   logic signed [COEF_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic signed [OFFS_W-1:0] offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RST;
         rfix_ff   <= RFIX_RST;
         coef_a_ff <= COEF_A_RST;
         coef_b_ff <= COEF_B_RST;
         coef_c_ff <= COEF_C_RST;
         gain_ff   <= GAIN_RST;
         offset_ff <= OFFS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SUPPLY: supply_ff <= csr_wdata[SUPPLY_W-1:0];
            CSR_RFIX:   rfix_ff   <= csr_wdata[RF_W-1:0];
            CSR_COEF_A: coef_a_ff <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_B: coef_b_ff <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_C: coef_c_ff <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_OFFSET: offset_ff <= $signed(csr_wdata[OFFS_W-1:0]);
            default: ;
         endcase
      end
   end

   // coefficient magnitudes for the sign-magnitude multipliers
   logic [COEF_W-1:0] cb_mag, cc_mag;
   logic              cb_neg, cc_neg;
   assign cb_neg = coef_b_ff[COEF_W-1];
   assign cc_neg = coef_c_ff[COEF_W-1];
   assign cb_mag = cb_neg ? COEF_W'(-coef_b_ff) : coef_b_ff;
   assign cc_mag = cc_neg ? COEF_W'(-coef_c_ff) : coef_c_ff;

   // ---------------------------------------------------------------
   // Flow control: the whole pipe moves unless the output is held
   // ---------------------------------------------------------------
   logic             adv;
   logic [DEPTH-1:0] vld_ff;

   assign adv       = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------
   // Stage registers
   // ---------------------------------------------------------------
   logic [NODE_W-1:0] in_v_ff,  in_v_in;
   logic [NODE_W-1:0] cv_ff,    cv_in;
   meta_type          m1_ff,    m1_in;
   logic [X1_W-1:0]   x1_ff,    x1_in;
   logic [NODE_W-1:0] xv_ff,    xv_in;
   meta_type          m2_ff,    m2_in;
   logic [X1_W-1:0]   x1b_ff,   x1b_in;
   logic [NODE_W-1:0] xvb_ff,   xvb_in;
   logic [5:0]        er_ff,    er_in;
   logic [4:0]        ev_ff,    ev_in;
   meta_type          m3_ff,    m3_in;

   // log2 squaring chain; index 0 holds the normalized mantissas
   logic [31:0] lm_r_ff [0:LOG_STEPS-1];
   logic [31:0] lm_v_ff [0:LOG_STEPS-1];
   logic [31:0] fr_r_ff [0:LOG_STEPS];
   logic [31:0] fr_v_ff [0:LOG_STEPS];
   logic [5:0]  le_r_ff [0:LOG_STEPS];
   logic [4:0]  le_v_ff [0:LOG_STEPS];
   meta_type    lmeta_ff[0:LOG_STEPS];
   logic [31:0] lm_r0_in, lm_v0_in;

   logic [LG_W-1:0]  lgm_ff,  lgm_in;
   logic             lgn_ff,  lgn_in;
   meta_type         m5_ff,   m5_in;
   logic [67:0]      pkh_ff,  pkh_in, pkl_ff, pkl_in;
   logic             kn_ff,   kn_in;
   meta_type         m6_ff,   m6_in;
   logic [LN_W-1:0]  ln_ff,   ln_in;
   logic             lnn_ff,  lnn_in;
   meta_type         m7_ff,   m7_in;
   logic [56:0]      qh_ff,   qh_in, ql_ff, ql_in;
   logic [66:0]      bh_ff,   bh_in, bl_ff, bl_in;
   logic [LN_W-1:0]  ln8_ff,  ln8_in;
   logic             lnn8_ff, lnn8_in, bn8_ff, bn8_in;
   meta_type         m8_ff,   m8_in;
   logic [LN2_W-1:0] ln2_ff,  ln2_in;
   logic [LN_W-1:0]  ln9_ff,  ln9_in;
   logic             lnn9_ff, lnn9_in;
   logic [PB_W-1:0]  pb9_ff,  pb9_in;
   logic             pbn9_ff, pbn9_in;
   meta_type         m9_ff,   m9_in;
   logic [62:0]      rh_ff,   rh_in, rl_ff, rl_in;
   logic             lnn10_ff, lnn10_in;
   logic [PB_W-1:0]  pb10_ff, pb10_in;
   logic             pbn10_ff, pbn10_in;
   meta_type         m10_ff,  m10_in;
   logic [LN3_W-1:0] ln3_ff,  ln3_in;
   logic             ln3n_ff, ln3n_in;
   logic [PB_W-1:0]  pb11_ff, pb11_in;
   logic             pbn11_ff, pbn11_in;
   meta_type         m11_ff,  m11_in;
   logic [72:0]      ch_ff,   ch_in, cl_ff, cl_in;
   logic             pcn12_ff, pcn12_in;
   logic [PB_W-1:0]  pb12_ff, pb12_in;
   logic             pbn12_ff, pbn12_in;
   meta_type         m12_ff,  m12_in;
   logic [PC_W-1:0]  pc13_ff, pc13_in;
   logic             pcn13_ff, pcn13_in;
   logic [PB_W-1:0]  pb13_ff, pb13_in;
   logic             pbn13_ff, pbn13_in;
   meta_type         m13_ff,  m13_in;
   logic signed [INV_W-1:0] inv_ff, inv_in;
   meta_type         m14_ff,  m14_in;
   logic [63:0]      num_ff,  num_in;
   logic [62:0]      ivn_ff,  ivn_in;
   meta_type         m15_ff,  m15_in;

   // restoring divider chain; index 0 holds the initial remainder
   logic [62:0]          rem_ff   [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] nlo_ff   [0:DIV_STEPS-1];
   logic [62:0]          div_iv_ff[0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] q_ff     [0:DIV_STEPS];
   logic                 dovf_ff  [0:DIV_STEPS];
   meta_type             dmeta_ff [0:DIV_STEPS];
   logic [NH_W-1:0]      nh0;
   logic                 dovf0_in;

   logic signed [42:0]  tc_ff,  tc_in;
   meta_type            m17_ff, m17_in;
   logic signed [60:0]  p_ff,   p_in;
   meta_type            m18_ff, m18_in;
   logic signed [TEMP_W-1:0]   temp_ff, temp_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;

   // ---------------------------------------------------------------
   // Front end: clamp, divider product, exponent, normalize
   // ---------------------------------------------------------------
   logic [NODE_W-1:0] lo_v, hi_v;
   logic              lo_hit;
   logic [SUPPLY_W-1:0] diff_v;

   always_comb begin
      in_v_in = req_node_uv;

      // low rail first, then high rail wins
      lo_hit = in_v_ff < RAIL_MARGIN_UV;
      lo_v   = lo_hit ? RAIL_MARGIN_UV : in_v_ff;
      hi_v   = supply_ff - RAIL_MARGIN_UV;
      cv_in  = (lo_v > hi_v) ? hi_v : lo_v;
      m1_in.clamped = lo_hit || (lo_v > hi_v);
      m1_in.inval   = (supply_ff <= RAIL_MARGIN_UV) || (rfix_ff == '0);

      diff_v = supply_ff - cv_ff;
      x1_in  = X1_W'(rfix_ff) * X1_W'(diff_v);
      xv_in  = cv_ff;
      m2_in  = m1_ff;

      er_in = '0;
      for (int i = 0; i < X1_W; i++) begin
         if (x1_ff[i]) er_in = 6'(i);
      end
      ev_in = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (xv_ff[i]) ev_in = 5'(i);
      end
      x1b_in = x1_ff;
      xvb_in = xv_ff;
      m3_in  = m2_ff;

      // mantissa in Q31, msb at bit 31
      lm_r0_in = 32'(({x1b_ff, 31'b0}) >> er_ff);
      lm_v0_in = 32'(({xvb_ff, 31'b0}) >> ev_ff);
   end

   // ---------------------------------------------------------------
   // log2 fraction: one squaring per stage, both lanes side by side
   // ---------------------------------------------------------------
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
      logic [63:0] sq_r, sq_v;
      logic [31:0] mr_in, mv_in, frr_in, frv_in;

      always_comb begin
         sq_r   = 64'(lm_r_ff[k]) * 64'(lm_r_ff[k]);
         sq_v   = 64'(lm_v_ff[k]) * 64'(lm_v_ff[k]);
         frr_in = fr_r_ff[k];
         frv_in = fr_v_ff[k];
         frr_in[LOG_STEPS-1-k] = sq_r[63];
         frv_in[LOG_STEPS-1-k] = sq_v[63];
         mr_in  = sq_r[63] ? sq_r[63:32] : sq_r[62:31];
         mv_in  = sq_v[63] ? sq_v[63:32] : sq_v[62:31];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            fr_r_ff[k+1]  <= frr_in;
            fr_v_ff[k+1]  <= frv_in;
            le_r_ff[k+1]  <= le_r_ff[k];
            le_v_ff[k+1]  <= le_v_ff[k];
            lmeta_ff[k+1] <= lmeta_ff[k];
         end
      end

      if (k < LOG_STEPS - 1) begin : g_mant
         always_ff @(posedge clock) begin
            if (adv) begin
               lm_r_ff[k+1] <= mr_in;
               lm_v_ff[k+1] <= mv_in;
            end
         end
      end else begin : g_last
         // mantissa is not needed past the last fraction bit
         logic unused_m;
         assign unused_m = ^{mr_in, mv_in};
      end
   end

   // ---------------------------------------------------------------
   // ln R, powers, Steinhart-Hart sum; every product split in two
   // ---------------------------------------------------------------
   logic [38:0] lg_diff;
   logic [98:0] ln_sum;
   logic [76:0] q_sum;
   logic [86:0] b_sum;
   logic [82:0] r_sum;
   logic [98:0] c_sum;
   logic signed [INV_W-1:0] sa, sb, sc;

   always_comb begin
      lg_diff = {1'b0, le_r_ff[LOG_STEPS], fr_r_ff[LOG_STEPS]}
              - {2'b0, le_v_ff[LOG_STEPS], fr_v_ff[LOG_STEPS]};
      lgn_in = lg_diff[38];
      lgm_in = lgn_in ? LG_W'(-lg_diff) : lg_diff[LG_W-1:0];
      m5_in  = lmeta_ff[LOG_STEPS];

      // times ln2 (Q60), split into two 30-bit halves
      pkh_in = 68'(lgm_ff) * 68'(LN2_HI);
      pkl_in = 68'(lgm_ff) * 68'(LN2_LO);
      kn_in  = lgn_ff;
      m6_in  = m5_ff;

      ln_sum = 99'({pkh_ff, 30'b0}) + 99'(pkl_ff) + (99'(1) << 59);
      ln_in  = ln_sum[60 +: LN_W];
      lnn_in = kn_ff;
      m7_in  = m6_ff;

      qh_in   = 57'(ln_ff) * 57'(ln_ff[37:19]);
      ql_in   = 57'(ln_ff) * 57'(ln_ff[18:0]);
      bh_in   = 67'(cb_mag) * 67'(ln_ff[37:19]);
      bl_in   = 67'(cb_mag) * 67'(ln_ff[18:0]);
      bn8_in  = cb_neg ^ lnn_ff;
      ln8_in  = ln_ff;
      lnn8_in = lnn_ff;
      m8_in   = m7_ff;

      q_sum   = 77'({qh_ff, 19'b0}) + 77'(ql_ff) + (77'(1) << 31);
      ln2_in  = q_sum[32 +: LN2_W];
      b_sum   = 87'({bh_ff, 19'b0}) + 87'(bl_ff) + (87'(1) << 31);
      pb9_in  = b_sum[32 +: PB_W];
      pbn9_in = bn8_ff;
      ln9_in  = ln8_ff;
      lnn9_in = lnn8_ff;
      m9_in   = m8_ff;

      rh_in    = 63'(ln2_ff) * 63'(ln9_ff[37:19]);
      rl_in    = 63'(ln2_ff) * 63'(ln9_ff[18:0]);
      lnn10_in = lnn9_ff;
      pb10_in  = pb9_ff;
      pbn10_in = pbn9_ff;
      m10_in   = m9_ff;

      r_sum    = 83'({rh_ff, 19'b0}) + 83'(rl_ff) + (83'(1) << 31);
      ln3_in   = r_sum[32 +: LN3_W];
      ln3n_in  = lnn10_ff;
      pb11_in  = pb10_ff;
      pbn11_in = pbn10_ff;
      m11_in   = m10_ff;

      ch_in    = 73'(cc_mag) * 73'(ln3_ff[49:25]);
      cl_in    = 73'(cc_mag) * 73'(ln3_ff[24:0]);
      pcn12_in = cc_neg ^ ln3n_ff;
      pb12_in  = pb11_ff;
      pbn12_in = pbn11_ff;
      m12_in   = m11_ff;

      c_sum    = 99'({ch_ff, 25'b0}) + 99'(cl_ff) + (99'(1) << 31);
      pc13_in  = c_sum[32 +: PC_W];
      pcn13_in = pcn12_ff;
      pb13_in  = pb12_ff;
      pbn13_in = pbn12_ff;
      m13_in   = m12_ff;

      sa = INV_W'(coef_a_ff);
      sb = $signed(INV_W'(pb13_ff));
      if (pbn13_ff) sb = -sb;
      sc = $signed(INV_W'(pc13_ff));
      if (pcn13_ff) sc = -sc;
      inv_in = sa + sb + sc;
      m14_in = m13_ff;

      // numerator for round-half-up of 100*2^F / inv
      ivn_in = inv_ff[62:0];
      num_in = NUM_BASE + 64'(inv_ff[62:1]);
      m15_in.clamped = m14_ff.clamped;
      m15_in.inval   = m14_ff.inval || inv_ff[INV_W-1] || (inv_ff == '0);

      nh0      = num_ff[63:DIV_STEPS];
      dovf0_in = 63'(nh0) >= ivn_ff;
   end

   // ---------------------------------------------------------------
   // Divider: one quotient bit per stage
   // ---------------------------------------------------------------
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [63:0]          r2;
      logic                 ge;
      logic [DIV_STEPS-1:0] q_in;
      logic [62:0]          r_in;

      always_comb begin
         r2   = {rem_ff[k], nlo_ff[k][DIV_STEPS-1-k]};
         ge   = r2 >= {1'b0, div_iv_ff[k]};
         r_in = ge ? 63'(r2 - {1'b0, div_iv_ff[k]}) : r2[62:0];
         q_in = q_ff[k];
         q_in[DIV_STEPS-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k+1]     <= q_in;
            dovf_ff[k+1]  <= dovf_ff[k];
            dmeta_ff[k+1] <= dmeta_ff[k];
         end
      end

      if (k < DIV_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1]    <= r_in;
               nlo_ff[k+1]    <= nlo_ff[k];
               div_iv_ff[k+1] <= div_iv_ff[k];
            end
         end
      end else begin : g_last
         logic unused_r;
         assign unused_r = ^r_in;
      end
   end

   // ---------------------------------------------------------------
   // Back end: cap, Kelvin offset, trim, saturate, status
   // ---------------------------------------------------------------
   logic [DIV_STEPS-1:0] ck;
   logic                 p_neg;
   logic [60:0]          p_mag, p_rnd;
   logic signed [46:0]   t_pre, t_sum;
   logic                 sat;

   always_comb begin
      ck = (dovf_ff[DIV_STEPS] || (q_ff[DIV_STEPS] > CK_CAP)) ? CK_CAP
                                                              : q_ff[DIV_STEPS];
      tc_in  = $signed({1'b0, ck}) - 43'sd27315;
      m17_in = dmeta_ff[DIV_STEPS];

      p_in   = 61'(tc_ff * $signed({1'b0, gain_ff}));
      m18_in = m17_ff;

      // Q16 trim, ties away from zero
      p_neg = p_ff[60];
      p_mag = p_neg ? 61'(-p_ff) : p_ff;
      p_rnd = p_mag + 61'd32768;
      t_pre = $signed({2'b00, p_rnd[60:16]});
      if (p_neg) t_pre = -t_pre;
      t_sum = t_pre + 47'(offset_ff);

      sat     = 1'b0;
      temp_in = t_sum[TEMP_W-1:0];
      if (t_sum > 47'(TEMP_MAX)) begin
         temp_in = TEMP_MAX;
         sat     = 1'b1;
      end
      if (t_sum < 47'(TEMP_MIN)) begin
         temp_in = TEMP_MIN;
         sat     = 1'b1;
      end

      priority if (m18_ff.inval) begin
         temp_in = '0;
         stat_in = ST_INVALID;
      end else if (sat) begin
         stat_in = ST_SAT;
      end else if (m18_ff.clamped) begin
         stat_in = ST_CLAMPED;
      end else begin
         stat_in = ST_OK;
      end
   end

   // ---------------------------------------------------------------
   // Payload registers (no reset)
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         in_v_ff <= in_v_in;
         cv_ff   <= cv_in;   m1_ff <= m1_in;
         x1_ff   <= x1_in;   xv_ff <= xv_in;   m2_ff <= m2_in;
         x1b_ff  <= x1b_in;  xvb_ff <= xvb_in;
         er_ff   <= er_in;   ev_ff <= ev_in;   m3_ff <= m3_in;

         lm_r_ff[0]  <= lm_r0_in;
         lm_v_ff[0]  <= lm_v0_in;
         fr_r_ff[0]  <= '0;
         fr_v_ff[0]  <= '0;
         le_r_ff[0]  <= er_ff;
         le_v_ff[0]  <= ev_ff;
         lmeta_ff[0] <= m3_ff;

         lgm_ff <= lgm_in;   lgn_ff <= lgn_in;  m5_ff <= m5_in;
         pkh_ff <= pkh_in;   pkl_ff <= pkl_in;  kn_ff <= kn_in;  m6_ff <= m6_in;
         ln_ff  <= ln_in;    lnn_ff <= lnn_in;  m7_ff <= m7_in;
         qh_ff  <= qh_in;    ql_ff  <= ql_in;
         bh_ff  <= bh_in;    bl_ff  <= bl_in;   bn8_ff <= bn8_in;
         ln8_ff <= ln8_in;   lnn8_ff <= lnn8_in; m8_ff <= m8_in;
         ln2_ff <= ln2_in;   pb9_ff <= pb9_in;  pbn9_ff <= pbn9_in;
         ln9_ff <= ln9_in;   lnn9_ff <= lnn9_in; m9_ff <= m9_in;
         rh_ff  <= rh_in;    rl_ff  <= rl_in;   lnn10_ff <= lnn10_in;
         pb10_ff <= pb10_in; pbn10_ff <= pbn10_in; m10_ff <= m10_in;
         ln3_ff <= ln3_in;   ln3n_ff <= ln3n_in;
         pb11_ff <= pb11_in; pbn11_ff <= pbn11_in; m11_ff <= m11_in;
         ch_ff  <= ch_in;    cl_ff  <= cl_in;   pcn12_ff <= pcn12_in;
         pb12_ff <= pb12_in; pbn12_ff <= pbn12_in; m12_ff <= m12_in;
         pc13_ff <= pc13_in; pcn13_ff <= pcn13_in;
         pb13_ff <= pb13_in; pbn13_ff <= pbn13_in; m13_ff <= m13_in;
         inv_ff <= inv_in;   m14_ff <= m14_in;
         num_ff <= num_in;   ivn_ff <= ivn_in;  m15_ff <= m15_in;

         rem_ff[0]    <= 63'(nh0);
         nlo_ff[0]    <= num_ff[DIV_STEPS-1:0];
         div_iv_ff[0] <= ivn_ff;
         q_ff[0]      <= '0;
         dovf_ff[0]   <= dovf0_in;
         dmeta_ff[0]  <= m15_ff;

         tc_ff   <= tc_in;   m17_ff <= m17_in;
         p_ff    <= p_in;    m18_ff <= m18_in;
         temp_ff <= temp_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_temp_centi_c = temp_ff;
   assign rsp_status       = stat_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `TSH_ASSERT_IMP(a_stall_only_on_held_rsp, clock, reset, req_stall, rsp_valid)
   `TSH_ASSERT_IMP(a_invalid_reads_zero, clock, reset, rsp_valid && (rsp_status == ST_INVALID), rsp_temp_centi_c == '0)
   `TSH_ASSERT_IMP(a_sat_at_bound, clock, reset, rsp_valid && (rsp_status == ST_SAT), (rsp_temp_centi_c == TEMP_MAX) || (rsp_temp_centi_c == TEMP_MIN))
   `TSH_ASSERT_NXT(a_accept_enters_pipe, clock, reset, req_valid && !req_stall, vld_ff[0])

endmodule
